/* hw/rtl/cla_pkg.sv */
// Shared types and constants for the complete-linkage agglomeration block.
package cla_pkg;

	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int DIST_W     = 32;
	localparam int DADDR_W    = 2 * IDX_W;

	// nearest-neighbour entry of one row
	typedef struct packed {
		logic              valid;
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] distance;
	} nn_entry_t;

	// one merge handed from the sequencer to the output stage
	typedef struct packed {
		logic [IDX_W-1:0]  lo;
		logic [IDX_W-1:0]  hi;
		logic [DIST_W-1:0] distance;
		logic              last;
	} merge_t;

	// matrix load transfer towards the sequencer
	typedef struct packed {
		logic               we;
		logic [DADDR_W-1:0] addr;
		logic [DIST_W-1:0]  data;
	} load_t;

endpackage

/* hw/rtl/complete_linkage_agglomeration_unit.sv */
// Top level: matrix load channel, point-count register and merge output stage.
// Usage:
//  The input channel (in_valid/in_ready) carries one distance matrix entry per
//  transfer: row_index, col_index, distance_value. Entries load at one per
//  cycle. A transfer with last_entry set stores its entry and starts the run.
//  During a run in_ready is low; the block then gives point_count - 1 merges
//  on the output channel (out_valid/out_ready), the final one with last_merge.
//  Run: initial rescans of every row; then for each merge a selection pass
//  over the nearest-neighbour memory, a row/column update over the distance
//  memory, a check pass over the nearest-neighbour memory, plus a rescan of
//  each row whose nearest neighbour was a merged point.
//  A result waits in the output register; if the receiver stalls, the next
//  merge holds until that register is taken. After the run in_ready returns.
//  cfg_we writes point_count (values above 64 act as 64, below 2 give no
//  merges); write it only while idle. Reset sets point_count to 64 and
//  returns to idle; matrix contents are undefined until loaded.
module complete_linkage_agglomeration_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cla_pkg::CNT_W-1:0]     cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [cla_pkg::IDX_W-1:0]     row_index,
	input  logic [cla_pkg::IDX_W-1:0]     col_index,
	input  logic [cla_pkg::DIST_W-1:0]    distance_value,
	input  logic                          last_entry,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [cla_pkg::IDX_W-1:0]     merge_low,
	output logic [cla_pkg::IDX_W-1:0]     merge_high,
	output logic [cla_pkg::DIST_W-1:0]    merge_distance,
	output logic                          last_merge
);

	logic [cla_pkg::CNT_W-1:0] point_count_q;
	logic [cla_pkg::CNT_W-1:0] n_clamped;
	logic                      idle;
	logic                      in_fire;
	logic                      emit_valid;
	logic                      emit_ready;
	cla_pkg::load_t            load;
	cla_pkg::merge_t           emit;
	cla_pkg::merge_t           out_q;
	logic                      out_valid_q;

	localparam logic [cla_pkg::CNT_W-1:0] MAXN = cla_pkg::CNT_W'(cla_pkg::MAX_POINTS);

	assign in_ready   = idle;
	assign in_fire    = in_valid && in_ready;
	assign n_clamped  = (point_count_q > MAXN) ? MAXN : point_count_q;
	assign load.we    = in_fire;
	assign load.addr  = {row_index, col_index};
	assign load.data  = distance_value;
	assign emit_ready = !out_valid_q || out_ready;

	cla_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.start     (in_fire && last_entry),
		.n_in      (n_clamped),
		.idle      (idle),
		.emit_valid(emit_valid),
		.emit_ready(emit_ready),
		.emit      (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= MAXN;
		end else if (cfg_we) begin
			point_count_q <= cfg_wdata;
		end
	end

	// output register: a merge waits here until transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (emit_ready) begin
			out_valid_q <= emit_valid;
			if (emit_valid) begin
				out_q <= emit;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign merge_low      = out_q.lo;
	assign merge_high     = out_q.hi;
	assign merge_distance = out_q.distance;
	assign last_merge     = out_q.last;

endmodule

/* hw/rtl/cla_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
module cla_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/cla_seq.sv */
// Agglomeration sequencer: owns the distance and nearest-neighbour memories.
module cla_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cla_pkg::load_t                load,
	input  logic                          start,
	input  logic [cla_pkg::CNT_W-1:0]     n_in,
	output logic                          idle,
	output logic                          emit_valid,
	input  logic                          emit_ready,
	output cla_pkg::merge_t               emit
);

	typedef enum logic [12:0] {
		ST_IDLE   = 13'b0000000000001,
		ST_CK_RD  = 13'b0000000000010,
		ST_CK_EV  = 13'b0000000000100,
		ST_RS     = 13'b0000000001000,
		ST_RS_WR  = 13'b0000000010000,
		ST_SEL    = 13'b0000000100000,
		ST_SEL_END = 13'b0000001000000,
		ST_EMIT   = 13'b0000010000000,
		ST_UPD_A  = 13'b0000100000000,
		ST_UPD_B  = 13'b0001000000000,
		ST_UPD_C  = 13'b0010000000000,
		ST_UPD_D  = 13'b0100000000000,
		ST_NN_LO  = 13'b1000000000000
	} state_t;

	localparam logic [cla_pkg::CNT_W-1:0] ONE = cla_pkg::CNT_W'(1);
	localparam logic [cla_pkg::CNT_W-1:0] TWO = cla_pkg::CNT_W'(2);

	state_t                           state_q;
	logic [cla_pkg::CNT_W-1:0]        n_q;
	logic [cla_pkg::IDX_W-1:0]        i_q;
	logic [cla_pkg::CNT_W-1:0]        j_q;
	logic                             pend_s1;
	logic [cla_pkg::IDX_W-1:0]        j_s1;
	logic                             have_q;
	logic [cla_pkg::DIST_W-1:0]       best_q;
	logic [cla_pkg::IDX_W-1:0]        bj_q;
	logic [cla_pkg::IDX_W-1:0]        nbr_q;
	logic [cla_pkg::IDX_W-1:0]        lo_q;
	logic [cla_pkg::IDX_W-1:0]        hi_q;
	logic [cla_pkg::DIST_W-1:0]       a_q;
	logic [cla_pkg::DIST_W-1:0]       m_q;
	logic [cla_pkg::IDX_W-1:0]        mc_q;
	logic                             init_q;
	logic [cla_pkg::MAX_POINTS-1:0]   active_q;

	logic                             d_we;
	logic [cla_pkg::DADDR_W-1:0]      d_waddr;
	logic [cla_pkg::DIST_W-1:0]       d_wdata;
	logic                             d_re;
	logic [cla_pkg::DADDR_W-1:0]      d_raddr;
	logic [cla_pkg::DIST_W-1:0]       d_rdata;
	logic                             n_we;
	logic [cla_pkg::IDX_W-1:0]        n_waddr;
	cla_pkg::nn_entry_t               n_wdata;
	logic                             n_re;
	logic [cla_pkg::IDX_W-1:0]        n_raddr;
	logic [$bits(cla_pkg::nn_entry_t)-1:0] n_rraw;
	cla_pkg::nn_entry_t               n_rdata;

	logic                             rs_issue;
	logic                             sel_issue;
	logic [cla_pkg::DIST_W-1:0]       m_c;
	logic                             i_last_chk;
	logic                             hit_chk;
	logic                             emit_fire;

	assign n_rdata    = cla_pkg::nn_entry_t'(n_rraw);
	assign idle       = (state_q == ST_IDLE);
	assign emit_valid = (state_q == ST_EMIT);
	assign emit_fire  = emit_valid && emit_ready;
	assign emit.lo    = lo_q;
	assign emit.hi    = hi_q;
	assign emit.distance = best_q;
	assign emit.last  = ({1'b0, mc_q} == (n_q - TWO));

	assign rs_issue   = (state_q == ST_RS) && (j_q < n_q);
	assign sel_issue  = (state_q == ST_SEL) && (j_q < (n_q - ONE));
	assign m_c        = (a_q > d_rdata) ? a_q : d_rdata;
	assign i_last_chk = (({1'b0, i_q} + TWO) >= n_q);
	assign hit_chk    = init_q || (active_q[i_q] && n_rdata.valid &&
		(n_rdata.idx == lo_q || n_rdata.idx == hi_q));

	cla_ram #(
		.WIDTH(cla_pkg::DIST_W),
		.DEPTH(cla_pkg::MAX_POINTS * cla_pkg::MAX_POINTS)
	) u_dist_ram (
		.clk  (clk),
		.we   (d_we),
		.waddr(d_waddr),
		.wdata(d_wdata),
		.re   (d_re),
		.raddr(d_raddr),
		.rdata(d_rdata)
	);

	cla_ram #(
		.WIDTH($bits(cla_pkg::nn_entry_t)),
		.DEPTH(cla_pkg::MAX_POINTS)
	) u_nn_ram (
		.clk  (clk),
		.we   (n_we),
		.waddr(n_waddr),
		.wdata(n_wdata),
		.re   (n_re),
		.raddr(n_raddr),
		.rdata(n_rraw)
	);

	// memory port control
	always_comb begin
		d_we    = 1'b0;
		d_waddr = load.addr;
		d_wdata = load.data;
		d_re    = 1'b0;
		d_raddr = {i_q, j_q[cla_pkg::IDX_W-1:0]};
		n_we    = 1'b0;
		n_waddr = i_q;
		n_wdata = '{valid: have_q, idx: bj_q, distance: best_q};
		n_re    = 1'b0;
		n_raddr = i_q;
		case (state_q)
			ST_IDLE: begin
				d_we = load.we;
			end
			ST_CK_RD: begin
				n_re = 1'b1;
			end
			ST_RS: begin
				d_re = rs_issue;
			end
			ST_RS_WR: begin
				n_we = 1'b1;
			end
			ST_SEL: begin
				n_re    = sel_issue;
				n_raddr = j_q[cla_pkg::IDX_W-1:0];
			end
			ST_UPD_A: begin
				d_re    = 1'b1;
				d_raddr = {lo_q, i_q};
				n_re    = 1'b1;
			end
			ST_UPD_B: begin
				d_re    = 1'b1;
				d_raddr = {hi_q, i_q};
			end
			ST_UPD_C: begin
				d_we    = 1'b1;
				d_waddr = {lo_q, i_q};
				d_wdata = m_c;
				n_we    = (i_q < lo_q) && (!n_rdata.valid || m_c < n_rdata.distance);
				n_wdata = '{valid: 1'b1, idx: lo_q, distance: m_c};
			end
			ST_UPD_D: begin
				d_we    = 1'b1;
				d_waddr = {i_q, lo_q};
				d_wdata = m_q;
			end
			ST_NN_LO: begin
				n_we    = 1'b1;
				n_waddr = lo_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			n_q      <= '0;
			i_q      <= '0;
			j_q      <= '0;
			pend_s1  <= 1'b0;
			j_s1     <= '0;
			have_q   <= 1'b0;
			best_q   <= '0;
			bj_q     <= '0;
			nbr_q    <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			a_q      <= '0;
			m_q      <= '0;
			mc_q     <= '0;
			init_q   <= 1'b0;
			active_q <= '1;
		end else begin
			pend_s1 <= rs_issue || sel_issue;
			j_s1    <= j_q[cla_pkg::IDX_W-1:0];

			// read data of the previous scan cycle
			if (pend_s1 && (state_q == ST_RS) && active_q[j_s1] &&
				(!have_q || d_rdata < best_q)) begin
				have_q <= 1'b1;
				best_q <= d_rdata;
				bj_q   <= j_s1;
			end
			if (pend_s1 && (state_q == ST_SEL) && active_q[j_s1] && n_rdata.valid &&
				(!have_q || n_rdata.distance < best_q)) begin
				have_q <= 1'b1;
				best_q <= n_rdata.distance;
				bj_q   <= j_s1;
				nbr_q  <= n_rdata.idx;
			end

			case (state_q)
				ST_IDLE: begin
					if (start) begin
						mc_q <= '0;
						if (n_in >= TWO) begin
							n_q     <= n_in;
							i_q     <= '0;
							init_q  <= 1'b1;
							for (int k = 0; k < cla_pkg::MAX_POINTS; k++) begin
								active_q[k] <= (cla_pkg::CNT_W'(k) < n_in);
							end
							state_q <= ST_CK_RD;
						end
					end
				end
				ST_CK_RD: begin
					state_q <= ST_CK_EV;
				end
				ST_CK_EV: begin
					if (hit_chk) begin
						have_q  <= 1'b0;
						j_q     <= {1'b0, i_q} + ONE;
						state_q <= ST_RS;
					end else if (!i_last_chk) begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_CK_RD;
					end else if (init_q) begin
						init_q  <= 1'b0;
						j_q     <= '0;
						have_q  <= 1'b0;
						state_q <= ST_SEL;
					end else if (({1'b0, mc_q} + ONE) == (n_q - ONE)) begin
						mc_q    <= mc_q + 1'b1;
						state_q <= ST_IDLE;
					end else begin
						mc_q    <= mc_q + 1'b1;
						j_q     <= '0;
						have_q  <= 1'b0;
						state_q <= ST_SEL;
					end
				end
				ST_RS: begin
					if (rs_issue) begin
						j_q <= j_q + ONE;
					end else begin
						state_q <= ST_RS_WR;
					end
				end
				ST_RS_WR: begin
					if (!i_last_chk) begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_CK_RD;
					end else if (init_q) begin
						init_q  <= 1'b0;
						j_q     <= '0;
						have_q  <= 1'b0;
						state_q <= ST_SEL;
					end else if (({1'b0, mc_q} + ONE) == (n_q - ONE)) begin
						mc_q    <= mc_q + 1'b1;
						state_q <= ST_IDLE;
					end else begin
						mc_q    <= mc_q + 1'b1;
						j_q     <= '0;
						have_q  <= 1'b0;
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					if (sel_issue) begin
						j_q <= j_q + ONE;
					end else begin
						state_q <= ST_SEL_END;
					end
				end
				ST_SEL_END: begin
					// no candidate left: the run stops early
					if (!have_q) begin
						state_q <= ST_IDLE;
					end else begin
						lo_q    <= (bj_q < nbr_q) ? bj_q : nbr_q;
						hi_q    <= (bj_q < nbr_q) ? nbr_q : bj_q;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_ready) begin
						active_q[hi_q] <= 1'b0;
						have_q         <= 1'b0;
						i_q            <= '0;
						state_q        <= ST_UPD_A;
					end
				end
				ST_UPD_A: begin
					if ((i_q == lo_q) || !active_q[i_q]) begin
						if ({1'b0, i_q} == (n_q - ONE)) begin
							state_q <= ST_NN_LO;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						state_q <= ST_UPD_B;
					end
				end
				ST_UPD_B: begin
					a_q     <= d_rdata;
					state_q <= ST_UPD_C;
				end
				ST_UPD_C: begin
					m_q <= m_c;
					if ((i_q > lo_q) && (!have_q || m_c < best_q)) begin
						have_q <= 1'b1;
						best_q <= m_c;
						bj_q   <= i_q;
					end
					state_q <= ST_UPD_D;
				end
				ST_UPD_D: begin
					if ({1'b0, i_q} == (n_q - ONE)) begin
						state_q <= ST_NN_LO;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_UPD_A;
					end
				end
				ST_NN_LO: begin
					i_q     <= '0;
					state_q <= ST_CK_RD;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_merge_order: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |-> (lo_q < hi_q))
		else $error("merge pair not ordered");

	a_hi_retired: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |=> !active_q[hi_q])
		else $error("merged point still active");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> ({1'b0, mc_q} < (n_q - ONE)))
		else $error("merge count beyond run length");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> !d_we)
		else $error("distance write while emitting");
`endif

endmodule

/* verif/complete_linkage_agglomeration_unit_tb.sv */
// Testbench for the complete-linkage agglomeration unit: random matrices, merge checks.
`timescale 1ns / 1ps

module complete_linkage_agglomeration_unit_tb;

	// Expected-merge predictor and merge checker.
	class merge_scoreboard;
		bit [cla_pkg::DIST_W-1:0] dmat [cla_pkg::MAX_POINTS][cla_pkg::MAX_POINTS];
		bit [cla_pkg::DIST_W-1:0] nn_dist [cla_pkg::MAX_POINTS];
		bit [cla_pkg::IDX_W-1:0]  nn_idx [cla_pkg::MAX_POINTS];
		bit                       nn_ok [cla_pkg::MAX_POINTS];
		bit                       alive [cla_pkg::MAX_POINTS];
		int unsigned              points = cla_pkg::MAX_POINTS;
		cla_pkg::merge_t          expected_merges [$];
		int                       errors = 0;

		function void set_points(int unsigned v);
			points = v;
		endfunction

		function void rescan(int i, int n);
			bit have;
			bit [cla_pkg::DIST_W-1:0] best;
			int bj;
			have = 0;
			best = '0;
			bj = 0;
			for (int j = i + 1; j < n; j++) begin
				if (alive[j] && (!have || dmat[i][j] < best)) begin
					have = 1;
					best = dmat[i][j];
					bj = j;
				end
			end
			nn_ok[i] = have;
			nn_dist[i] = have ? best : '0;
			nn_idx[i] = have ? cla_pkg::IDX_W'(bj) : '0;
		endfunction

		function void agglomerate();
			int n, row, lo, hi, bj;
			bit found, have;
			bit [cla_pkg::DIST_W-1:0] dmin, bd, a, b, m;
			cla_pkg::merge_t mg;
			n = (points > cla_pkg::MAX_POINTS) ? cla_pkg::MAX_POINTS : points;
			if (n < 2)
				return;
			for (int i = 0; i < cla_pkg::MAX_POINTS; i++) begin
				alive[i] = (i < n);
				nn_ok[i] = 0;
			end
			for (int i = 0; i + 1 < n; i++)
				rescan(i, n);
			for (int k = 0; k < n - 1; k++) begin
				found = 0;
				dmin = '0;
				row = 0;
				for (int i = 0; i + 1 < n; i++) begin
					if (alive[i] && nn_ok[i] && (!found || nn_dist[i] < dmin)) begin
						found = 1;
						dmin = nn_dist[i];
						row = i;
					end
				end
				if (!found)
					return;
				lo = (row < nn_idx[row]) ? row : nn_idx[row];
				hi = (row < nn_idx[row]) ? nn_idx[row] : row;
				mg.lo = cla_pkg::IDX_W'(lo);
				mg.hi = cla_pkg::IDX_W'(hi);
				mg.distance = dmin;
				mg.last = (k == n - 2);
				expected_merges.push_back(mg);
				alive[hi] = 0;
				have = 0;
				bd = '0;
				bj = 0;
				for (int i = 0; i < n; i++) begin
					if (!alive[i] || i == lo)
						continue;
					a = dmat[lo][i];
					b = dmat[hi][i];
					m = (a > b) ? a : b;
					dmat[lo][i] = m;
					dmat[i][lo] = m;
					if (lo < i) begin
						if (!have || m < bd) begin
							have = 1;
							bd = m;
							bj = i;
						end
					end else if (!nn_ok[i] || m < nn_dist[i]) begin
						nn_ok[i] = 1;
						nn_dist[i] = m;
						nn_idx[i] = cla_pkg::IDX_W'(lo);
					end
				end
				nn_ok[lo] = have;
				nn_dist[lo] = have ? bd : '0;
				nn_idx[lo] = have ? cla_pkg::IDX_W'(bj) : '0;
				for (int i = 0; i + 1 < n; i++)
					if (alive[i] && nn_ok[i] && (nn_idx[i] == lo || nn_idx[i] == hi))
						rescan(i, n);
			end
		endfunction

		function void note_entry(bit [cla_pkg::IDX_W-1:0] r, bit [cla_pkg::IDX_W-1:0] c,
				bit [cla_pkg::DIST_W-1:0] d, bit fin);
			dmat[r][c] = d;
			if (fin)
				agglomerate();
		endfunction

		function void check_merge(cla_pkg::merge_t got);
			cla_pkg::merge_t exp_m;
			if (expected_merges.size() == 0) begin
				$error("unexpected merge lo=%0d hi=%0d", got.lo, got.hi);
				errors++;
				return;
			end
			exp_m = expected_merges.pop_front();
			if (got.lo !== exp_m.lo) begin
				$error("merge_low: expected %0d, got %0d", exp_m.lo, got.lo);
				errors++;
			end
			if (got.hi !== exp_m.hi) begin
				$error("merge_high: expected %0d, got %0d", exp_m.hi, got.hi);
				errors++;
			end
			if (got.distance !== exp_m.distance) begin
				$error("merge_distance: expected %0h, got %0h", exp_m.distance,
					got.distance);
				errors++;
			end
			if (got.last !== exp_m.last) begin
				$error("last_merge: expected %0d, got %0d", exp_m.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic                       clk = 0;
	logic                       arst_n = 0;
	logic                       cfg_we = 0;
	logic [cla_pkg::CNT_W-1:0]  cfg_wdata = '0;
	logic                       in_valid = 0;
	logic                       in_ready;
	logic [cla_pkg::IDX_W-1:0]  row_index = '0;
	logic [cla_pkg::IDX_W-1:0]  col_index = '0;
	logic [cla_pkg::DIST_W-1:0] distance_value = '0;
	logic                       last_entry = 0;
	logic                       out_valid;
	logic                       out_ready = 0;
	logic [cla_pkg::IDX_W-1:0]  merge_low;
	logic [cla_pkg::IDX_W-1:0]  merge_high;
	logic [cla_pkg::DIST_W-1:0] merge_distance;
	logic                       last_merge;

	merge_scoreboard sb = new();
	bit   quiet = 0;
	int   entries_sent = 0;

	complete_linkage_agglomeration_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .row_index(row_index),
		.col_index(col_index), .distance_value(distance_value), .last_entry(last_entry),
		.out_valid(out_valid), .out_ready(out_ready), .merge_low(merge_low),
		.merge_high(merge_high), .merge_distance(merge_distance), .last_merge(last_merge)
	);

	always #5 clk = ~clk;

	task automatic send_entry(int r, int c, bit [cla_pkg::DIST_W-1:0] d, bit fin);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			@(negedge clk) in_valid = 0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1;
		row_index = cla_pkg::IDX_W'(r);
		col_index = cla_pkg::IDX_W'(c);
		distance_value = d;
		last_entry = fin;
		do @(posedge clk); while (!(in_valid && in_ready));
		sb.note_entry(cla_pkg::IDX_W'(r), cla_pkg::IDX_W'(c), d, fin);
		entries_sent++;
	endtask

	task automatic write_points(int v);
		@(negedge clk);
		in_valid = 0;
		cfg_we = 1;
		cfg_wdata = cla_pkg::CNT_W'(v);
		@(negedge clk) cfg_we = 0;
		sb.set_points(v);
	endtask

	function automatic bit [cla_pkg::DIST_W-1:0] pick_dist(int mode);
		case (mode)
			1: return $urandom_range(0, 3);
			2: return $urandom_range(0, 1) ? '1 : '0;
			default: return $urandom();
		endcase
	endfunction

	// Loads a full matrix (mode: 0 wide random, 1 tie-heavy, 2 extremes) and runs it.
	task automatic run_matrix(int cfg, int mode, bit asym, bit noisy);
		int n, r, c;
		bit [cla_pkg::DIST_W-1:0] d;
		write_points(cfg);
		n = (cfg > cla_pkg::MAX_POINTS) ? cla_pkg::MAX_POINTS : cfg;
		if (n < 2) begin
			send_entry($urandom_range(0, 63), $urandom_range(0, 63), $urandom(), 0);
			send_entry($urandom_range(0, 63), $urandom_range(0, 63), $urandom(), 1);
		end else begin
			for (int i = 0; i < n; i++) begin
				for (int j = i; j < n; j++) begin
					d = pick_dist(mode);
					send_entry(i, j, d, 0);
					if (i != j)
						send_entry(j, i, asym ? pick_dist(mode) : d, 0);
					// stray entry, in a row outside the points in use
					if (noisy && $urandom_range(0, 9) == 0)
						send_entry($urandom_range(n, 63), $urandom_range(0, 63),
							$urandom(), 0);
				end
			end
			r = $urandom_range(0, n - 1);
			c = $urandom_range(0, n - 1);
			send_entry(r, c, pick_dist(mode), 1);
		end
		@(negedge clk) in_valid = 0;
		wait (sb.expected_merges.size() == 0);
		// the block finishes its last update pass before it takes input again
		do @(posedge clk); while (!in_ready);
	endtask

	// merge receiver with random stalls
	initial begin
		int w;
		cla_pkg::merge_t got;
		forever begin
			w = quiet ? 0 : $urandom_range(0, 17);
			if (w > 0) begin
				@(negedge clk) out_ready = 0;
				repeat (w - 1) @(negedge clk);
			end
			@(negedge clk) out_ready = 1;
			do @(posedge clk); while (!(out_valid && out_ready));
			got.lo = merge_low;
			got.hi = merge_high;
			got.distance = merge_distance;
			got.last = last_merge;
			sb.check_merge(got);
		end
	end

	initial begin
		#50_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// directed: smallest count, ties, extremes, tiny counts
		run_matrix(2, 2, 0, 0);
		run_matrix(3, 1, 0, 0);
		run_matrix(4, 2, 1, 0);
		run_matrix(1, 0, 0, 0);
		run_matrix(0, 0, 0, 0);

		while (entries_sent < 200) begin
			quiet = ($urandom_range(0, 4) == 0);
			run_matrix($urandom_range(2, 8), $urandom_range(0, 2),
				$urandom_range(0, 3) == 0, $urandom_range(0, 1));
		end
		quiet = 0;

		wait (sb.expected_merges.size() == 0);
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.expected_merges.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
